// ===== rtl/core/psc_pkg.sv =====
// Shared types and constants for the period-based speed PID controller.
`timescale 1ns / 1ps

package psc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_P_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_I_GAIN       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_D_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_P_TERM_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT    = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int ELIM_W     = 12;

    // Datapath widths
    localparam int SET_W    = 12;
    localparam int PER_W    = 16;
    localparam int QUO_W    = 17;
    localparam int SPEED_W  = 12;
    localparam int DIFF_W   = 13;
    localparam int ERR_W    = 14;
    localparam int INT_W    = 18;
    localparam int PROD_W   = 35;
    localparam int ACC_W    = 37;
    localparam int DRIVE_W  = 17;

    // Speed conversion constants
    localparam logic [QUO_W-1:0]          SPEED_NUM    = 17'd100000;
    localparam logic signed [QUO_W:0]     SPEED_OFFSET = 18'sd10;
    localparam logic signed [QUO_W:0]     SPEED_MAX    = 18'sd1700;
    localparam logic signed [DRIVE_W-1:0] STOP_DRIVE   = -17'sd65535;

    localparam logic [ELIM_W-1:0]     ELIM_RESET = 12'd600;
    localparam logic [CFG_DATA_W-1:0] PLIM_RESET = 16'd600;
    localparam logic [CFG_DATA_W-1:0] ILIM_RESET = 16'd6000;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] p_gain;
        logic [CFG_DATA_W-1:0] i_gain;
        logic [CFG_DATA_W-1:0] d_gain;
        logic [CFG_DATA_W-1:0] output_limit;
        logic [ELIM_W-1:0]     error_limit;
        logic [CFG_DATA_W-1:0] p_term_limit;
        logic [CFG_DATA_W-1:0] integral_limit;
    } cfg_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic             chan;
        logic [SET_W-1:0] setpoint;
        logic [PER_W-1:0] period;
        logic             stop;
        logic             zero_period;
    } item_t;

endpackage

// ===== rtl/core/psc_front.sv =====
// Input queue: accepts items and classifies stopped and zero-period cases.
`timescale 1ns / 1ps

module psc_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic                      channel,
    input  logic [psc_pkg::SET_W-1:0] setpoint,
    input  logic [psc_pkg::PER_W-1:0] period,
    output psc_pkg::item_t            item,
    output logic                      item_valid,
    input  logic                      item_ready
);
    import psc_pkg::*;

    localparam int DEPTH = 2;

    item_t       entries_reg [DEPTH];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        wr_en;
    logic        rd_en;
    item_t       cls;

    always_comb
    begin
        cls.chan        = channel;
        cls.setpoint    = setpoint;
        cls.period      = period;
        cls.stop        = (setpoint == '0);
        cls.zero_period = (period == '0);
    end

    assign full       = (count_reg == 2'(DEPTH));
    assign wr_en      = push && !full;
    assign item_valid = (count_reg != '0);
    assign rd_en      = item_valid && item_ready;
    assign item       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/psc_div.sv =====
// Restoring divider: 100000 divided by the period, one quotient bit a cycle.
`timescale 1ns / 1ps

module psc_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [psc_pkg::PER_W-1:0] divisor,
    output logic                      done,
    output logic [psc_pkg::QUO_W-1:0] quotient
);
    import psc_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [PER_W-1:0] rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [PER_W-1:0] div_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [PER_W:0]   trial;
    logic             fits;

    assign trial    = {rem_reg, quo_reg[QUO_W-1]};
    assign fits     = (trial >= {1'b0, div_reg});
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift the dividend out of the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= SPEED_NUM;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? PER_W'(trial - {1'b0, div_reg}) : trial[PER_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/core/psc_back.sv =====
// Controller sequencer: speed, error, integral with clamp, three products, output queue.
`timescale 1ns / 1ps

module psc_back
#(
    parameter int CHANNELS = 2
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  psc_pkg::cfg_t                      cfg,
    input  psc_pkg::item_t                     item,
    input  logic                               item_valid,
    output logic                               item_ready,
    output logic signed [psc_pkg::DRIVE_W-1:0] drive,
    output logic                               stopped,
    output logic                               empty,
    input  logic                               pop
);
    import psc_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_ERR   = 4'd2;
    localparam logic [3:0] S_INT   = 4'd3;
    localparam logic [3:0] S_MP    = 4'd4;
    localparam logic [3:0] S_MI    = 4'd5;
    localparam logic [3:0] S_MD    = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_CLAMP = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam int OQ_DEPTH = 2;

    logic [3:0]                 state_reg;
    logic [3:0]                 state_next;
    item_t                      cur_reg;
    logic [CH_W-1:0]            ch_idx;

    logic signed [INT_W-1:0]    int_reg  [CHANNELS];
    logic signed [SPEED_W-1:0]  prev_reg [CHANNELS];

    logic signed [SPEED_W-1:0]  speed_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic signed [INT_W-1:0]    sum_reg;
    logic                       psat_reg;
    logic                       isat_reg;
    logic signed [DRIVE_W-1:0]  ival_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [DRIVE_W-1:0]  res_drive_reg;
    logic                       res_stop_reg;

    logic                       div_start;
    logic                       div_done;
    logic [QUO_W-1:0]           div_quo;
    logic signed [QUO_W:0]      speed_raw;
    logic signed [SPEED_W-1:0]  speed_calc;

    logic signed [ERR_W-1:0]    elim_s;
    logic signed [INT_W:0]      ilim_s;
    logic signed [INT_W:0]      sum_w;
    logic signed [ACC_W-1:0]    olim_s;

    logic [CFG_DATA_W-1:0]      mul_a;
    logic signed [INT_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]   mul_p;

    // Result queue
    logic signed [DRIVE_W-1:0]  oq_drive_reg [OQ_DEPTH];
    logic                       oq_stop_reg  [OQ_DEPTH];
    logic                       oq_wr_ptr_reg;
    logic                       oq_rd_ptr_reg;
    logic [1:0]                 oq_count_reg;
    logic                       oq_wr;
    logic                       oq_rd;

    assign ch_idx     = (CHANNELS > 1) ? CH_W'(cur_reg.chan) : '0;
    assign item_ready = (state_reg == S_IDLE);
    assign div_start  = item_ready && item_valid && !item.stop && !item.zero_period;

    psc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (item.period),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Speed is forced to zero above the top of the range
    assign speed_raw  = $signed({1'b0, div_quo}) - SPEED_OFFSET;
    assign speed_calc = (speed_raw > SPEED_MAX) ? '0 : speed_raw[SPEED_W-1:0];

    assign elim_s = $signed({2'b00, cfg.error_limit});
    assign ilim_s = $signed({3'b000, cfg.integral_limit});
    assign olim_s = $signed({{(ACC_W-CFG_DATA_W){1'b0}}, cfg.output_limit});
    assign sum_w  = (INT_W+1)'(int_reg[ch_idx]) + (INT_W+1)'(err_reg);

    // One shared multiplier, its product registered before use
    always_comb
    begin
        case (state_reg)
            S_MP:
            begin
                mul_a = cfg.p_gain;
                mul_b = INT_W'(err_reg);
            end
            S_MI:
            begin
                mul_a = cfg.i_gain;
                mul_b = sum_reg;
            end
            default:
            begin
                mul_a = cfg.d_gain;
                mul_b = INT_W'(diff_reg);
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.stop)
                    begin
                        state_next = S_OUT;
                    end
                    else if (item.zero_period)
                    begin
                        state_next = S_ERR;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:   state_next = S_INT;
            S_INT:   state_next = S_MP;
            S_MP:    state_next = S_MI;
            S_MI:    state_next = S_MD;
            S_MD:    state_next = S_SUM;
            S_SUM:   state_next = S_CLAMP;
            S_CLAMP: state_next = S_OUT;
            S_OUT:
            begin
                if (oq_count_reg != 2'(OQ_DEPTH))
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign oq_wr = (state_reg == S_OUT) && (oq_count_reg != 2'(OQ_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int k = 0; k < CHANNELS; k++)
            begin
                int_reg[k]  <= '0;
                prev_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_ERR)
            begin
                prev_reg[ch_idx] <= speed_reg;
            end
            if (state_reg == S_INT)
            begin
                if (sum_w > ilim_s)
                begin
                    int_reg[ch_idx] <= INT_W'(ilim_s);
                end
                else if (sum_w < -ilim_s)
                begin
                    int_reg[ch_idx] <= INT_W'(-ilim_s);
                end
                else
                begin
                    int_reg[ch_idx] <= INT_W'(sum_w);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        case (state_reg)
            S_IDLE:
            begin
                cur_reg       <= item;
                speed_reg     <= '0;
                res_drive_reg <= STOP_DRIVE;
                res_stop_reg  <= 1'b1;
            end
            S_DIV:
            begin
                speed_reg <= speed_calc;
            end
            S_ERR:
            begin
                err_reg  <= ERR_W'($signed({1'b0, cur_reg.setpoint})) - ERR_W'(speed_reg);
                diff_reg <= DIFF_W'(prev_reg[ch_idx]) - DIFF_W'(speed_reg);
            end
            S_INT:
            begin
                // Saturated P enters the sum at once; unsaturated P follows its product
                psat_reg <= 1'b1;
                if (err_reg > elim_s)
                begin
                    acc_reg <= ACC_W'($signed({1'b0, cfg.p_term_limit}));
                end
                else if (err_reg < -elim_s)
                begin
                    acc_reg <= -ACC_W'($signed({1'b0, cfg.p_term_limit}));
                end
                else
                begin
                    acc_reg  <= '0;
                    psat_reg <= 1'b0;
                end
                isat_reg <= 1'b1;
                if (sum_w > ilim_s)
                begin
                    sum_reg  <= INT_W'(ilim_s);
                    ival_reg <= DRIVE_W'(ilim_s);
                end
                else if (sum_w < -ilim_s)
                begin
                    sum_reg  <= INT_W'(-ilim_s);
                    ival_reg <= DRIVE_W'(-ilim_s);
                end
                else
                begin
                    sum_reg  <= INT_W'(sum_w);
                    ival_reg <= '0;
                    isat_reg <= 1'b0;
                end
            end
            S_MI:
            begin
                if (!psat_reg)
                begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                end
            end
            S_MD:
            begin
                acc_reg <= acc_reg + (isat_reg ? ACC_W'(ival_reg) : ACC_W'(prod_reg));
            end
            S_SUM:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            S_CLAMP:
            begin
                res_stop_reg <= 1'b0;
                if (acc_reg > olim_s)
                begin
                    res_drive_reg <= DRIVE_W'(olim_s);
                end
                else if (acc_reg < -olim_s)
                begin
                    res_drive_reg <= DRIVE_W'(-olim_s);
                end
                else
                begin
                    res_drive_reg <= DRIVE_W'(acc_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result queue
    assign empty   = (oq_count_reg == '0);
    assign oq_rd   = pop && !empty;
    assign drive   = oq_drive_reg[oq_rd_ptr_reg];
    assign stopped = oq_stop_reg[oq_rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= 1'b0;
            oq_rd_ptr_reg <= 1'b0;
            oq_count_reg  <= '0;
        end
        else
        begin
            if (oq_wr)
            begin
                oq_wr_ptr_reg <= ~oq_wr_ptr_reg;
            end
            if (oq_rd)
            begin
                oq_rd_ptr_reg <= ~oq_rd_ptr_reg;
            end
            if (oq_wr && !oq_rd)
            begin
                oq_count_reg <= oq_count_reg + 2'd1;
            end
            else if (!oq_wr && oq_rd)
            begin
                oq_count_reg <= oq_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (oq_wr)
        begin
            oq_drive_reg[oq_wr_ptr_reg] <= res_drive_reg;
            oq_stop_reg[oq_wr_ptr_reg]  <= res_stop_reg;
        end
    end

    // Check the channel just updated, while the current item names it
    a_int_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MP) |->
        ((int_reg[ch_idx] <= 18'sd65535) && (int_reg[ch_idx] >= -18'sd65535)))
        else $error("integral sum outside its clamp range");

    a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        oq_count_reg <= 2'(OQ_DEPTH))
        else $error("result queue over-filled");

    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (oq_wr && !res_stop_reg) |->
        ((ACC_W'(res_drive_reg) <= olim_s) && (ACC_W'(res_drive_reg) >= -olim_s)))
        else $error("drive written beyond output limit");

    a_div_only_when_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished outside the divide step");

endmodule

// ===== rtl/core/period_speed_pid_controller.sv =====
// Top level: configuration registers, input queue and controller sequencer.
`timescale 1ns / 1ps

// Two-channel PID speed controller fed with pulse periods. Each item passes from
// acceptance to its queued result through the one-bit-a-cycle divider that
// turns the period into a speed (17 quotient bits), then through the error,
// integral clamp and the three products, which share one multiplier. A zero
// setpoint (stopped) skips the divider and the arithmetic, a zero period skips
// the divider only. Two items wait in the input queue and two results in the
// output queue. Configuration is written through cfg_valid/cfg_index/cfg_data
// and is always ready; indexes beyond the register list are dropped.
module period_speed_pid_controller
#(
    parameter int CHANNELS = 2
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                channel,
    input  logic [psc_pkg::SET_W-1:0]           setpoint,
    input  logic [psc_pkg::PER_W-1:0]           period,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [psc_pkg::DRIVE_W-1:0]  drive,
    output logic                                stopped,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [psc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [psc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import psc_pkg::*;

    cfg_t  cfg_reg;
    item_t item;
    logic  item_valid;
    logic  item_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.p_gain         <= '0;
            cfg_reg.i_gain         <= '0;
            cfg_reg.d_gain         <= '0;
            cfg_reg.output_limit   <= '0;
            cfg_reg.error_limit    <= ELIM_RESET;
            cfg_reg.p_term_limit   <= PLIM_RESET;
            cfg_reg.integral_limit <= ILIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_P_GAIN:       cfg_reg.p_gain         <= cfg_data;
                CFG_I_GAIN:       cfg_reg.i_gain         <= cfg_data;
                CFG_D_GAIN:       cfg_reg.d_gain         <= cfg_data;
                CFG_OUTPUT_LIMIT: cfg_reg.output_limit   <= cfg_data;
                CFG_ERROR_LIMIT:  cfg_reg.error_limit    <= cfg_data[ELIM_W-1:0];
                CFG_P_TERM_LIMIT: cfg_reg.p_term_limit   <= cfg_data;
                CFG_INT_LIMIT:    cfg_reg.integral_limit <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    psc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .channel    (channel),
        .setpoint   (setpoint),
        .period     (period),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready)
    );

    psc_back
    #(
        .CHANNELS (CHANNELS)
    )
    u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item       (item),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .drive      (drive),
        .stopped    (stopped),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the period-based two-channel speed PID controller.
`timescale 1ns / 1ps

module tb_top;

    import psc_pkg::*;

    localparam int CHANNELS        = 2;
    localparam int HALF_PERIOD     = 2;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 40;
    localparam int TAIL_CYCLES     = 60;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int REPORT_LIMIT    = 10;
    localparam int RAND_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 285;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int HOLD_SPACING    = 600;

    localparam longint RATE_TICKS = 100000;
    localparam longint SPEED_BIAS = 10;
    localparam longint SPEED_CEIL = 1700;
    localparam logic signed [DRIVE_W-1:0] STOPPED_DRIVE = -17'sd65535;

    // Index past the end of the register list: writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    typedef enum bit [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_t;

    typedef struct {
        op_kind_t             kind;
        bit                   chan;
        bit [SET_W-1:0]       sp;
        bit [PER_W-1:0]       per;
        bit [CFG_IDX_W-1:0]   idx;
        bit [CFG_DATA_W-1:0]  data;
    } stim_op_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      stopped;
    } drive_beat_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic                         channel = 1'b0;
    logic [SET_W-1:0]             setpoint = '0;
    logic [PER_W-1:0]             period = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic signed [DRIVE_W-1:0]    drive;
    logic                         stopped;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    // Controller settings and per-channel state as the block should hold them
    cfg_t                         ctrl_cfg;
    logic signed [INT_W-1:0]      stored_integral [CHANNELS] = '{default: '0};
    logic signed [SPEED_W-1:0]    stored_speed [CHANNELS] = '{default: '0};

    stim_op_t                     stim_ops [$];
    drive_beat_t                  awaited_drives [$];
    stim_op_t                     cur_op;
    drive_beat_t                  exp_beat;

    bit                           op_active = 1'b0;
    bit                           beat_taken = 1'b0;
    int                           gap_left = 0;
    int                           burst_left = 1;
    int                           settle_left = 0;
    int                           hold_left = 0;
    int                           next_hold_at = 500;
    int                           rx_mode = 0;
    int                           rx_mode_left = 0;

    int                           cycle_count = 0;
    int                           items_sent = 0;
    int                           cfg_writes = 0;
    int                           results_seen = 0;
    int                           stopped_seen = 0;
    int                           holds_done = 0;
    int                           output_clamps = 0;
    int                           integral_clamps = 0;
    int                           fault_count = 0;

    period_speed_pid_controller #(.CHANNELS(CHANNELS)) dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .channel   (channel),
        .setpoint  (setpoint),
        .period    (period),
        .empty     (empty),
        .pop       (pop),
        .drive     (drive),
        .stopped   (stopped),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void store_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_P_GAIN:       ctrl_cfg.p_gain         = data;
            CFG_I_GAIN:       ctrl_cfg.i_gain         = data;
            CFG_D_GAIN:       ctrl_cfg.d_gain         = data;
            CFG_OUTPUT_LIMIT: ctrl_cfg.output_limit   = data;
            CFG_ERROR_LIMIT:  ctrl_cfg.error_limit    = data[ELIM_W-1:0];
            CFG_P_TERM_LIMIT: ctrl_cfg.p_term_limit   = data;
            CFG_INT_LIMIT:    ctrl_cfg.integral_limit = data;
            default: ;
        endcase
    endfunction

    // Work out the drive for one item and advance the channel state
    function automatic drive_beat_t compute_drive(input bit chan, input bit [SET_W-1:0] sp,
                                                  input bit [PER_W-1:0] per);
        drive_beat_t res;
        int unsigned slot;
        longint      speed;
        longint      err;
        longint      pterm;
        longint      iterm;
        longint      dterm;
        longint      total;
        longint      acc;
        longint      elim;
        longint      ilim;
        longint      olim;

        slot = 32'(chan) % CHANNELS;
        elim = longint'(ctrl_cfg.error_limit);
        ilim = longint'(ctrl_cfg.integral_limit);
        olim = longint'(ctrl_cfg.output_limit);
        res.stopped = 1'b0;
        if (sp == '0)
        begin
            res.drive   = STOPPED_DRIVE;
            res.stopped = 1'b1;
            return res;
        end

        // zero period counts as over-speed
        if (per == '0)
            speed = 0;
        else
        begin
            speed = RATE_TICKS / longint'(per) - SPEED_BIAS;
            if (speed > SPEED_CEIL)
                speed = 0;
        end
        err = longint'(sp) - speed;

        if (err > elim)
            pterm = longint'(ctrl_cfg.p_term_limit);
        else if (err < -elim)
            pterm = -longint'(ctrl_cfg.p_term_limit);
        else
            pterm = longint'(ctrl_cfg.p_gain) * err;

        // on clamping the I term is the limit itself, not gain times limit
        acc = longint'(stored_integral[slot]) + err;
        if (acc > ilim)
        begin
            iterm = ilim;
            stored_integral[slot] = INT_W'(ilim);
            integral_clamps++;
        end
        else if (acc < -ilim)
        begin
            iterm = -ilim;
            stored_integral[slot] = INT_W'(-ilim);
            integral_clamps++;
        end
        else
        begin
            stored_integral[slot] = INT_W'(acc);
            iterm = longint'(ctrl_cfg.i_gain) * acc;
        end

        dterm = longint'(ctrl_cfg.d_gain) * (longint'(stored_speed[slot]) - speed);
        stored_speed[slot] = SPEED_W'(speed);

        total = pterm + iterm + dterm;
        if (total > olim)
        begin
            total = olim;
            output_clamps++;
        end
        else if (total < -olim)
        begin
            total = -olim;
            output_clamps++;
        end
        res.drive = total[DRIVE_W-1:0];
        return res;
    endfunction

    function automatic bit [CFG_DATA_W-1:0] pick_setting(input int unsigned top);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_DATA_W'(top);
            2, 3, 4: return CFG_DATA_W'($urandom_range(0, 16));
            default: return CFG_DATA_W'($urandom_range(0, top));
        endcase
    endfunction

    task automatic add_item(input bit chan, input bit [SET_W-1:0] sp, input bit [PER_W-1:0] per);
        stim_op_t op;
        op.kind = OP_ITEM;
        op.chan = chan;
        op.sp   = sp;
        op.per  = per;
        stim_ops.push_back(op);
    endtask

    task automatic add_cfg(input bit [CFG_IDX_W-1:0] idx, input bit [CFG_DATA_W-1:0] data);
        stim_op_t op;
        op.kind = OP_CFG;
        op.idx  = idx;
        op.data = data;
        stim_ops.push_back(op);
    endtask

    task automatic add_drain();
        stim_op_t op;
        op.kind = OP_DRAIN;
        stim_ops.push_back(op);
    endtask

    // Sender: one beat offered at a time, in bursts with gaps between them
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_taken)
            begin
                beat_taken = 1'b0;
                op_active  = 1'b0;
                if (cur_op.kind == OP_ITEM)
                begin
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
            end
            if (!op_active)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (settle_left > 0)
                    settle_left--;
                else if (stim_ops.size() != 0)
                begin
                    if (stim_ops[0].kind == OP_DRAIN)
                    begin
                        // hold until every result is back, then let the block settle
                        if (awaited_drives.size() == 0)
                        begin
                            void'(stim_ops.pop_front());
                            settle_left = SETTLE_CYCLES;
                        end
                    end
                    else
                    begin
                        cur_op    = stim_ops.pop_front();
                        op_active = 1'b1;
                    end
                end
            end
            push      <= op_active && cur_op.kind == OP_ITEM;
            cfg_valid <= op_active && cur_op.kind == OP_CFG;
            channel   <= cur_op.chan;
            setpoint  <= cur_op.sp;
            period    <= cur_op.per;
            cfg_index <= cur_op.idx;
            cfg_data  <= cur_op.data;
        end
    end

    // Receiver: stall pattern that changes mode, plus long hold-offs to fill the block
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left == 0 && items_sent >= next_hold_at)
            begin
                hold_left     = RX_HOLD_CYCLES;
                next_hold_at += HOLD_SPACING;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 2);
                    rx_mode_left = $urandom_range(16, 160);
                end
                rx_mode_left--;
                case (rx_mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    default: pop <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Monitor: record accepted beats and check each result against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
            begin
                awaited_drives.push_back(compute_drive(channel, setpoint, period));
                items_sent++;
                beat_taken = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                store_setting(cfg_index, cfg_data);
                cfg_writes++;
                beat_taken = 1'b1;
            end
            if (pop && !empty)
            begin
                results_seen++;
                if (awaited_drives.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("result %0d arrived with nothing awaited: drive %0d stopped %0b",
                                 results_seen, drive, stopped);
                end
                else
                begin
                    exp_beat = awaited_drives.pop_front();
                    if (exp_beat.stopped)
                        stopped_seen++;
                    if (drive !== exp_beat.drive || stopped !== exp_beat.stopped)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_LIMIT)
                            $display("result %0d mismatch: drive exp %0d got %0d, stopped exp %0b got %0b",
                                     results_seen, exp_beat.drive, drive, exp_beat.stopped, stopped);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_drives.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        bit               r_chan;
        bit [SET_W-1:0]   r_sp;
        bit [PER_W-1:0]   r_per;

        ctrl_cfg                = '0;
        ctrl_cfg.error_limit    = 12'd600;
        ctrl_cfg.p_term_limit   = 16'd600;
        ctrl_cfg.integral_limit = 16'd6000;

        // reset settings: zero gains and zero output limit hold drive at 0 unless stopped
        add_item(1'b0, 12'd0, 16'd1000);
        add_item(1'b0, 12'd100, 16'd1000);
        add_item(1'b1, 12'd4095, 16'd0);
        add_drain();
        add_cfg(CFG_P_GAIN, 16'd1);
        add_cfg(CFG_I_GAIN, 16'd1);
        add_cfg(CFG_D_GAIN, 16'd1);
        add_cfg(CFG_OUTPUT_LIMIT, 16'hFFFF);
        add_cfg(CFG_UNUSED_IDX, 16'hFFFF);
        add_item(1'b0, 12'd690, 16'd1000);    // error sits exactly on the error limit
        add_item(1'b0, 12'd691, 16'd1000);
        add_item(1'b1, 12'd4095, 16'd0);
        add_item(1'b1, 12'd1, 16'd59);        // fastest speed below the over-speed cut
        add_item(1'b1, 12'd1, 16'd58);
        add_item(1'b0, 12'd4095, 16'hFFFF);   // slowest speed, negative
        add_item(1'b1, 12'd1, 16'd1);
        add_item(1'b0, 12'd0, 16'hFFFF);
        add_drain();
        add_cfg(CFG_P_GAIN, 16'hFFFF);
        add_cfg(CFG_I_GAIN, 16'hFFFF);
        add_cfg(CFG_D_GAIN, 16'hFFFF);
        add_cfg(CFG_ERROR_LIMIT, 16'd4095);
        add_cfg(CFG_P_TERM_LIMIT, 16'hFFFF);
        add_cfg(CFG_INT_LIMIT, 16'd0);
        add_item(1'b0, 12'd4095, 16'd0);
        add_item(1'b1, 12'd4095, 16'hFFFF);
        add_item(1'b1, 12'd1, 16'd59);
        add_drain();
        // both integral sums are zero now: land them exactly on each limit
        add_cfg(CFG_P_GAIN, 16'd0);
        add_cfg(CFG_I_GAIN, 16'd2);
        add_cfg(CFG_D_GAIN, 16'd0);
        add_cfg(CFG_ERROR_LIMIT, 16'd0);
        add_cfg(CFG_P_TERM_LIMIT, 16'd0);
        add_cfg(CFG_INT_LIMIT, 16'd100);
        add_item(1'b0, 12'd190, 16'd1000);
        add_item(1'b1, 12'd1, 16'd900);
        add_item(1'b0, 12'd190, 16'd1000);

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            add_drain();
            add_cfg(CFG_P_GAIN, pick_setting(16'hFFFF));
            add_cfg(CFG_I_GAIN, pick_setting(16'hFFFF));
            add_cfg(CFG_D_GAIN, pick_setting(16'hFFFF));
            add_cfg(CFG_OUTPUT_LIMIT, pick_setting(16'hFFFF));
            add_cfg(CFG_ERROR_LIMIT, pick_setting(4095));
            add_cfg(CFG_P_TERM_LIMIT, pick_setting(16'hFFFF));
            add_cfg(CFG_INT_LIMIT, pick_setting(16'hFFFF));
            if ($urandom_range(0, 1) == 1)
                add_cfg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                r_chan = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 15))
                    0:       r_sp = '0;
                    1:       r_sp = 12'd4095;
                    2, 3, 4, 5, 6, 7, 8:
                             r_sp = SET_W'($urandom_range(1, 1800));
                    default: r_sp = SET_W'($urandom_range(1, 4095));
                endcase
                case ($urandom_range(0, 15))
                    0:       r_per = '0;
                    1:       r_per = 16'hFFFF;
                    2, 3:    r_per = PER_W'($urandom_range(1, 70));
                    4, 5, 6, 7, 8, 9, 10:
                             r_per = PER_W'($urandom_range(55, 2000));
                    default: r_per = PER_W'($urandom);
                endcase
                add_item(r_chan, r_sp, r_per);
            end
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_ops.size() != 0 || op_active || awaited_drives.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (awaited_drives.size() != 0)
        begin
            fault_count += awaited_drives.size();
            $display("%0d predicted results never arrived", awaited_drives.size());
        end
        if (fault_count > REPORT_LIMIT)
            $display("%0d mismatches in total, only the first %0d shown", fault_count, REPORT_LIMIT);

        $display("Covered %0d items (%0d stopped) and %0d register writes, %0d receiver hold-offs",
                 items_sent, stopped_seen, cfg_writes, holds_done);
        $display("Drive clamped %0d times, integral clamped %0d times, %0d cycles",
                 output_clamps, integral_clamps, cycle_count);
        if (fault_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/psc_pkg.sv
rtl/core/psc_front.sv
rtl/core/psc_div.sv
rtl/core/psc_back.sv
rtl/core/period_speed_pid_controller.sv
test/tb_top.sv
